// File: rtl/core/lkc_pkg.sv
// Shared constants and types for the LRU key cache core.
// No dependencies; every other file imports this package.
package lkc_pkg;

  localparam int ENTRIES    = 16;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int KEY_W      = 32;
  localparam int SLOT_OUT_W = 4;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [IDX_W-1:0] idx_t;

  // Outcome of the directory search for one key.
  typedef struct packed {
    logic hit;
    idx_t slot;
    logic ev_valid;
    key_t ev_key;
  } lookup_t;

  // Directory update request.
  typedef struct packed {
    logic en;
    logic miss;
    idx_t slot;
    key_t key;
  } upd_t;

endpackage

// File: rtl/core/lkc_in_if.sv
// Lookup request channel: valid/ready handshake carrying one key.
// Depends on lkc_pkg.
interface lkc_in_if
  import lkc_pkg::*;
();
  logic valid;
  logic ready;
  key_t lookup_key;

  modport source (output valid, output lookup_key, input ready);
  modport sink   (input valid, input lookup_key, output ready);
endinterface

// File: rtl/core/lkc_out_if.sv
// Lookup result channel: valid/ready handshake carrying one result.
// Depends on lkc_pkg.
interface lkc_out_if
  import lkc_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [SLOT_OUT_W-1:0] slot_index;
  logic                  evicted_valid;
  key_t                  evicted_key;
  logic                  bad_key;

  modport source (output valid, output hit, output slot_index, output evicted_valid,
                  output evicted_key, output bad_key, input ready);
  modport sink   (input valid, input hit, input slot_index, input evicted_valid,
                  input evicted_key, input bad_key, output ready);
endinterface

// File: rtl/core/lkc_lookup.sv
// Parallel key compare and victim selection over all directory slots.
// Depends on lkc_pkg.
module lkc_lookup
  import lkc_pkg::*;
(
  input  key_t          key,
  input  key_t          keys     [ENTRIES],
  input  logic          occupied [ENTRIES],
  input  idx_t          rank     [ENTRIES],
  output lookup_t       res
);

  logic hit_any;
  idx_t hit_slot;
  idx_t lru_slot;

  always_comb begin
    hit_any  = 1'b0;
    hit_slot = '0;
    lru_slot = '0;
    // scan downward so the lowest matching slot wins
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (occupied[i] && keys[i] == key) begin
        hit_any  = 1'b1;
        hit_slot = IDX_W'(i);
      end
      if (rank[i] == IDX_W'(ENTRIES - 1)) begin
        lru_slot = IDX_W'(i);
      end
    end
  end

  always_comb begin
    res.hit      = hit_any;
    res.slot     = hit_any ? hit_slot : lru_slot;
    res.ev_valid = !hit_any && occupied[lru_slot];
    res.ev_key   = res.ev_valid ? keys[lru_slot] : '0;
  end

endmodule

// File: rtl/core/lkc_dir.sv
// Directory storage: slot keys, occupancy flags and recency ranks.
// Depends on lkc_pkg.
module lkc_dir
  import lkc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  upd_t upd,
  output key_t keys     [ENTRIES],
  output logic occupied [ENTRIES],
  output idx_t rank     [ENTRIES]
);

  idx_t rank_sel;

  assign rank_sel = rank[upd.slot];

  // keys carry no reset; occupancy gates every use
  always_ff @(posedge clk) begin
    if (upd.en && upd.miss) begin
      keys[upd.slot] <= upd.key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        occupied[i] <= 1'b0;
        rank[i]     <= IDX_W'(i);
      end
    end else if (upd.en) begin
      if (upd.miss) begin
        occupied[upd.slot] <= 1'b1;
      end
      // promote the slot, age everything more recent than it
      for (int i = 0; i < ENTRIES; i++) begin
        if (IDX_W'(i) == upd.slot) begin
          rank[i] <= '0;
        end else if (rank[i] < rank_sel) begin
          rank[i] <= rank[i] + 1'b1;
        end
      end
    end
  end

  logic [ENTRIES-1:0] is_mru;
  logic [ENTRIES-1:0] is_lru;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      is_mru[i] = (rank[i] == '0);
      is_lru[i] = (rank[i] == IDX_W'(ENTRIES - 1));
    end
  end

  a_one_mru : assert property (@(posedge clk) disable iff (rst) $onehot(is_mru))
    else $error("recency ranks hold no single most recent slot");
  a_one_lru : assert property (@(posedge clk) disable iff (rst) $onehot(is_lru))
    else $error("recency ranks hold no single least recent slot");
  a_promote : assert property (@(posedge clk) disable iff (rst)
    upd.en |=> rank[$past(upd.slot)] == '0)
    else $error("accessed slot did not become most recent");
  a_fill : assert property (@(posedge clk) disable iff (rst)
    (upd.en && upd.miss) |=> occupied[$past(upd.slot)] && keys[$past(upd.slot)] == $past(upd.key))
    else $error("miss did not record key in its slot");

endmodule

// File: rtl/core/lru_key_cache_core.sv
// LRU key cache core: fully associative 16-slot key directory, LRU replacement.
// Each accepted key is held in the input register; its result is then captured in the
//   result register, which waits while an earlier result is still held and not taken.
// Throughput: one lookup per cycle while the result channel is not stalled; the key
//   compare and rank update happen between the input register and the result register.
// Reset (synchronous): all slots empty, slot i at rank i, so the first miss fills
//   the last slot. No clearing pass; lookups are accepted right after reset.
module lru_key_cache_core
  import lkc_pkg::*;
(
  input logic      clk,
  input logic      rst,
  lkc_in_if.sink   lookup,
  lkc_out_if.source result
);

  // Input register stage.
  logic s1_valid;
  key_t s1_key;

  // Result register stage.
  logic                  out_valid;
  logic                  out_hit;
  logic [SLOT_OUT_W-1:0] out_slot;
  logic                  out_ev_valid;
  key_t                  out_ev_key;
  logic                  out_bad;

  logic    advance;
  logic    bad;
  lookup_t lk;
  upd_t    upd;

  key_t dir_keys     [ENTRIES];
  logic dir_occupied [ENTRIES];
  idx_t dir_rank     [ENTRIES];

  // Advance the held key whenever the result register is free or draining.
  assign advance      = s1_valid && (!out_valid || result.ready);
  assign lookup.ready = !s1_valid || advance;
  assign bad          = (s1_key == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (lookup.ready) begin
      s1_valid <= lookup.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (lookup.ready && lookup.valid) begin
      s1_key <= lookup.lookup_key;
    end
  end

  lkc_lookup u_lookup (
    .key      (s1_key),
    .keys     (dir_keys),
    .occupied (dir_occupied),
    .rank     (dir_rank),
    .res      (lk)
  );

  // Drop state updates for a zero key; it only raises the flag.
  always_comb begin
    upd.en   = advance && !bad;
    upd.miss = !lk.hit;
    upd.slot = lk.slot;
    upd.key  = s1_key;
  end

  lkc_dir u_dir (
    .clk      (clk),
    .rst      (rst),
    .upd      (upd),
    .keys     (dir_keys),
    .occupied (dir_occupied),
    .rank     (dir_rank)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Capture the result; zero every field but the flag for a bad key.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_bad      <= bad;
      out_hit      <= !bad && lk.hit;
      out_slot     <= bad ? '0 : SLOT_OUT_W'(lk.slot);
      out_ev_valid <= !bad && lk.ev_valid;
      out_ev_key   <= bad ? '0 : lk.ev_key;
    end
  end

  assign result.valid         = out_valid;
  assign result.hit           = out_hit;
  assign result.slot_index    = out_slot;
  assign result.evicted_valid = out_ev_valid;
  assign result.evicted_key   = out_ev_key;
  assign result.bad_key       = out_bad;

endmodule

// File: bench/tb_top.sv
// Self-checking testbench for lru_key_cache_core: directed and random key lookups
// with random stalls on both channels, checked by an in-bench LRU directory model.
// Depends on lkc_pkg, lkc_in_if, lkc_out_if and the lru_key_cache_core RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lkc_pkg::*;

  // Random part sizing: the final stretch runs with no idling on either side.
  localparam int RANDOM_ITEMS   = 1128;
  localparam int TAIL_ITEMS     = 150;
  localparam int SEGMENT_ITEMS  = 64;
  localparam int POOL_SIZE      = 24;
  // Extra idle time after the last predicted result has been seen.
  localparam int DRAIN_CYCLES   = 6;
  // Longest legal quiet spell is a source gap plus a sink stall plus the core latency.
  localparam int WATCHDOG_LIMIT = 1000;

  // One result transaction, laid out in port order.
  typedef struct packed {
    logic                  hit;
    logic [SLOT_OUT_W-1:0] slot_index;
    logic                  evicted_valid;
    key_t                  evicted_key;
    logic                  bad_key;
  } cache_result_t;

  // LRU directory model plus the queue of results it has predicted but not yet seen.
  class lookup_scoreboard;
    key_t          slot_key  [ENTRIES];
    bit            slot_used [ENTRIES];
    int            slot_age  [ENTRIES];   // 0 = most recent, ENTRIES-1 = next victim
    cache_result_t expected_results[$];
    int unsigned   errors;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        slot_key[i]  = '0;
        slot_used[i] = 1'b0;
        slot_age[i]  = i;
      end
      errors = 0;
    endfunction

    function string show(cache_result_t r);
      return $sformatf("hit=%0b slot=%0d ev_valid=%0b ev_key=%08h bad_key=%0b",
                       r.hit, r.slot_index, r.evicted_valid, r.evicted_key, r.bad_key);
    endfunction

    function void report(string detail);
      if (errors < 10) $display("[%0t] ERROR: %s", $realtime, detail);
      errors++;
    endfunction

    // Predict the result of one accepted lookup and advance the directory.
    function void note_lookup(key_t key);
      cache_result_t r;
      int slot;
      int prev_age;
      r = '0;
      if (key == '0) begin
        // Zero key: flag it, touch nothing.
        r.bad_key = 1'b1;
        expected_results.push_back(r);
        return;
      end
      slot = -1;
      for (int i = 0; i < ENTRIES; i++)
        if (slot < 0 && slot_used[i] && slot_key[i] == key) slot = i;
      r.hit = (slot >= 0);
      if (slot < 0) begin
        for (int i = 0; i < ENTRIES; i++)
          if (slot_age[i] == ENTRIES - 1) slot = i;
        if (slot_used[slot]) begin
          r.evicted_valid = 1'b1;
          r.evicted_key   = slot_key[slot];
        end
        slot_key[slot]  = key;
        slot_used[slot] = 1'b1;
      end
      prev_age = slot_age[slot];
      for (int i = 0; i < ENTRIES; i++)
        if (slot_age[i] < prev_age) slot_age[i]++;
      slot_age[slot] = 0;
      r.slot_index = SLOT_OUT_W'(slot);
      expected_results.push_back(r);
    endfunction

    // Compare one accepted result with the oldest prediction.
    function void check_result(cache_result_t got);
      cache_result_t want;
      if (expected_results.size() == 0) begin
        report({"result with no lookup pending: ", show(got)});
        return;
      end
      want = expected_results.pop_front();
      if (got !== want)
        report({"result mismatch, expected ", show(want), " actual ", show(got)});
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  lkc_in_if  lookup_ch ();
  lkc_out_if result_ch ();

  lru_key_cache_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .lookup (lookup_ch),
    .result (result_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lookup_scoreboard sb;

  // Idle knobs, retuned per segment of the random part.
  int unsigned src_gap_pct  = 15;
  int unsigned stall_pct    = 15;
  bit          quiet_tail   = 1'b0;
  int          stall_left   = 0;
  int          idle_cycles  = 0;
  bit          timed_out    = 1'b0;

  // Result sink: drop ready in random bursts; hold it high in the tail.
  always @(negedge clk) begin
    if (rst || quiet_tail) begin
      result_ch.ready <= 1'b1;
      stall_left      <= 0;
    end else if (stall_left > 0) begin
      result_ch.ready <= 1'b0;
      stall_left      <= stall_left - 1;
    end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
      result_ch.ready <= 1'b0;
      stall_left      <= $urandom_range(0, 16);
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // Monitor both channels at the rising edge. Check results before noting the
  // lookup of the same edge, since a result can never belong to it.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (result_ch.valid && result_ch.ready)
        sb.check_result({result_ch.hit, result_ch.slot_index, result_ch.evicted_valid,
                         result_ch.evicted_key, result_ch.bad_key});
      if (lookup_ch.valid && lookup_ch.ready)
        sb.note_lookup(lookup_ch.lookup_key);
      if ((result_ch.valid && result_ch.ready) || (lookup_ch.valid && lookup_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one key, called and returning at a falling edge. Optionally idle the
  // source first; otherwise keep valid high straight into the next transaction.
  task automatic send_lookup(input key_t key);
    if (src_gap_pct > 0 && $urandom_range(99) < src_gap_pct) begin
      lookup_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    lookup_ch.valid      <= 1'b1;
    lookup_ch.lookup_key <= key;
    do @(posedge clk); while (!lookup_ch.ready);
    @(negedge clk);
  endtask

  initial begin
    // Directed opening: zero key on an empty cache, the all-ones and single-bit
    // keys, a repeat on the most recent slot, a full fill of all sixteen slots,
    // a hit on an older slot, then misses that evict occupied slots.
    key_t directed_keys [23] = '{
      32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
      32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_FFFF, 32'hFFFF_0000, 32'h0000_0002,
      32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'h1234_5678, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
      32'h0001_0000, 32'h0000_0100, 32'hDEAD_BEEF, 32'h0000_0001, 32'h0000_0001,
      32'h0000_0000, 32'h0000_0004, 32'hFFFF_FFFF
    };
    int unsigned idle_levels [4] = '{0, 8, 25, 60};
    key_t key_pool [POOL_SIZE];
    key_t key;
    key_t last_key;
    int   pool_span;
    int   sel;

    sb = new();
    rst                  = 1'b1;
    lookup_ch.valid      = 1'b0;
    lookup_ch.lookup_key = '0;
    result_ch.ready      = 1'b0;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    pool_span = POOL_SIZE;
    last_key  = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    fork
      begin
        foreach (directed_keys[i]) send_lookup(directed_keys[i]);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
          // Retune idling and the working set per segment; go quiet for the tail.
          if (n == RANDOM_ITEMS - TAIL_ITEMS) begin
            quiet_tail  = 1'b1;
            src_gap_pct = 0;
            stall_pct   = 0;
          end else if (n % SEGMENT_ITEMS == 0 && !quiet_tail) begin
            src_gap_pct = idle_levels[$urandom_range(3)];
            stall_pct   = idle_levels[$urandom_range(3)];
            pool_span   = $urandom_range(6, POOL_SIZE);
          end

          // Mostly keys from a working set near the cache size, so hits, evictions
          // and repeats on the most recent slot all happen; the rest is zero keys,
          // one-bit near misses and fully random keys.
          sel = $urandom_range(99);
          if (sel < 4)
            key = '0;
          else if (sel < 10)
            key = last_key;
          else if (sel < 72)
            key = key_pool[$urandom_range(pool_span - 1)];
          else if (sel < 84)
            key = key_pool[$urandom_range(pool_span - 1)] ^ (key_t'(1) << $urandom_range(31));
          else
            key = $urandom;

          // Slowly drift the working set.
          if ($urandom_range(39) == 0) key_pool[$urandom_range(POOL_SIZE - 1)] = $urandom;

          send_lookup(key);
          last_key = key;
        end

        lookup_ch.valid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
      end
      begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
        timed_out = 1'b1;
      end
    join_any
    disable fork;

    if (timed_out) begin
      $display("[%0t] watchdog: no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
      $display("*** FAILED ***");
    end else begin
      if (sb.expected_results.size() != 0)
        sb.report($sformatf("%0d lookups never produced a result",
                            sb.expected_results.size()));
      if (sb.errors == 0)
        $display("*** PASSED ***");
      else
        $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
